>>> rtl/kvrfv_pkg.sv
// Shared types and constants for the key/value record file validator.
`default_nettype none
package kvrfv_pkg;
	localparam int unsigned HdrLen = 24;
	localparam logic [31:0] HashStart = 32'h811C9DC5;
	localparam logic [31:0] HashMul = 32'h01000193;
	localparam logic [31:0] TagWord = 32'h54445349;
	localparam logic [24:0] CountCap = 25'h1FFFFFF;

	localparam logic [2:0] CFG_MAX_RECORDS = 3'd0;
	localparam logic [2:0] CFG_MAX_KEY_LEN = 3'd1;
	localparam logic [2:0] CFG_MAX_STRING_LEN = 3'd2;
	localparam logic [2:0] CFG_MAX_PAYLOAD_LEN = 3'd3;
	localparam logic [2:0] CFG_EXPECTED_VERSION = 3'd4;

	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_SHORT = 4'd1;
	localparam logic [3:0] ST_BIG = 4'd2;
	localparam logic [3:0] ST_MAGIC = 4'd3;
	localparam logic [3:0] ST_COUNT = 4'd4;
	localparam logic [3:0] ST_HASH = 4'd5;
	localparam logic [3:0] ST_KEY = 4'd6;
	localparam logic [3:0] ST_STRING = 4'd7;
	localparam logic [3:0] ST_TYPE = 4'd8;
	localparam logic [3:0] ST_TRUNC = 4'd9;
	localparam logic [3:0] ST_TRAIL = 4'd10;

	typedef enum logic [8:0] {
		PH_TYPE  = 9'b000000001,
		PH_KLEN0 = 9'b000000010,
		PH_KLEN1 = 9'b000000100,
		PH_KEY   = 9'b000001000,
		PH_VLEN0 = 9'b000010000,
		PH_VLEN1 = 9'b000100000,
		PH_VLEN2 = 9'b001000000,
		PH_VLEN3 = 9'b010000000,
		PH_VALUE = 9'b100000000
	} phase_t;

	// classified byte from the front part
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_hdr;
		logic [4:0] hdr_idx;
	} item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] record_count;
		logic [31:0] payload_hash;
		logic [63:0] sequence_number;
	} result_t;

	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		begin
			x = h ^ {24'd0, b};
			// multiply by 0x01000193 as shifts and adds
			fnv_step = x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
		end
	endfunction
endpackage
`default_nettype wire

>>> rtl/kvrfv_if.sv
// Valid/ready channel interface.
`default_nettype none
interface kvrfv_if #(parameter int unsigned W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/kvrfv_front.sv
// Front part: accepts bytes and tags them with header position.
`default_nettype none
module kvrfv_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_last,
	output logic               q_valid,
	input  wire logic          q_ready,
	output kvrfv_pkg::item_t   q_item
);
	import kvrfv_pkg::*;
	logic [4:0] hdr_cnt_q;
	logic [1:0] cnt_q;
	item_t      buf_q [2];
	logic       rp_q, wp_q;
	logic       acc, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign acc = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			cnt_q <= '0;
			rp_q <= 1'b0;
			wp_q <= 1'b0;
		end else begin
			if (acc) begin
				wp_q <= ~wp_q;
				if (in_last) hdr_cnt_q <= '0;
				else if (hdr_cnt_q != 5'(HdrLen)) hdr_cnt_q <= hdr_cnt_q + 5'd1;
			end
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q[wp_q].data <= in_byte;
			buf_q[wp_q].last <= in_last;
			buf_q[wp_q].is_hdr <= (hdr_cnt_q != 5'(HdrLen));
			buf_q[wp_q].hdr_idx <= hdr_cnt_q;
		end
	end
endmodule
`default_nettype wire

>>> rtl/kvrfv_back.sv
// Back part: header capture, hash, record walk and final status.
`default_nettype none
module kvrfv_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         q_valid,
	output logic              q_ready,
	input  kvrfv_pkg::item_t  q_item,
	output logic              out_valid,
	input  wire logic         out_ready,
	output kvrfv_pkg::result_t out_res
);
	import kvrfv_pkg::*;
	logic [31:0] max_records_q, max_string_len_q, expected_version_q;
	logic [15:0] max_key_len_q;
	logic [23:0] max_payload_len_q;

	logic [63:0] w0_q, w1_q, w2_q;
	logic [31:0] hash_q;
	logic [24:0] pay_q;
	logic [31:0] recs_q, rem_q, vlen_q;
	logic [7:0]  rtype_q;
	phase_t      ph_q;
	logic [3:0]  fault_q;

	logic  acc;
	assign q_ready = !out_valid || out_ready;
	assign acc = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_records_q <= 32'd50000;
			max_key_len_q <= 16'd256;
			max_string_len_q <= 32'd16384;
			max_payload_len_q <= 24'd1048576;
			expected_version_q <= 32'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_RECORDS: max_records_q <= cfg_data;
				CFG_MAX_KEY_LEN: max_key_len_q <= cfg_data[15:0];
				CFG_MAX_STRING_LEN: max_string_len_q <= cfg_data;
				CFG_MAX_PAYLOAD_LEN: max_payload_len_q <= cfg_data[23:0];
				CFG_EXPECTED_VERSION: expected_version_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next-state of the walk for the current byte
	logic [63:0] w0_n, w1_n, w2_n;
	logic [31:0] hash_n, recs_n, rem_n, vlen_n;
	logic [24:0] pay_n;
	logic [7:0]  rtype_n;
	phase_t      ph_n;
	logic [3:0]  fault_n, st;
	logic [15:0] klen;
	logic [31:0] rem_dec, vlen_full;
	logic        close_ok;
	logic [7:0]  b;

	always_comb begin
		b = q_item.data;
		w0_n = w0_q; w1_n = w1_q; w2_n = w2_q;
		hash_n = hash_q; pay_n = pay_q; recs_n = recs_q; rem_n = rem_q;
		vlen_n = vlen_q; rtype_n = rtype_q; ph_n = ph_q; fault_n = fault_q;
		klen = {b, rem_q[7:0]};
		rem_dec = rem_q - 32'd1;
		vlen_full = {b, vlen_q[23:0]};
		close_ok = (rtype_q == 8'd2) || (rtype_q == 8'd1 && vlen_q == 32'd4);
		if (q_item.is_hdr) begin
			unique case (q_item.hdr_idx[4:3])
				2'd0: w0_n[{q_item.hdr_idx[2:0], 3'b000} +: 8] = b;
				2'd1: w1_n[{q_item.hdr_idx[2:0], 3'b000} +: 8] = b;
				default: w2_n[{q_item.hdr_idx[2:0], 3'b000} +: 8] = b;
			endcase
		end else begin
			hash_n = fnv_step(hash_q, b);
			if (pay_q != CountCap) pay_n = pay_q + 25'd1;
			if (fault_q == ST_OK) begin
				if (recs_q == w1_q[31:0]) fault_n = ST_TRAIL;
				else begin
					unique case (ph_q)
						PH_TYPE: begin rtype_n = b; ph_n = PH_KLEN0; end
						PH_KLEN0: begin rem_n = {24'd0, b}; ph_n = PH_KLEN1; end
						PH_KLEN1: begin
							if (klen == 16'd0 || klen > max_key_len_q) fault_n = ST_KEY;
							else begin rem_n = {16'd0, klen}; ph_n = PH_KEY; end
						end
						PH_KEY: begin
							rem_n = rem_dec;
							if (rem_dec == 32'd0) begin vlen_n = '0; ph_n = PH_VLEN0; end
						end
						PH_VLEN0: begin vlen_n = {24'd0, b}; ph_n = PH_VLEN1; end
						PH_VLEN1: begin vlen_n = {16'd0, b, vlen_q[7:0]}; ph_n = PH_VLEN2; end
						PH_VLEN2: begin vlen_n = {8'd0, b, vlen_q[15:0]}; ph_n = PH_VLEN3; end
						PH_VLEN3: begin
							vlen_n = vlen_full;
							if (rtype_q == 8'd2 && vlen_full > max_string_len_q)
								fault_n = ST_STRING;
							else if (vlen_full == 32'd0) begin
								if (rtype_q == 8'd2) begin
									recs_n = recs_q + 32'd1; ph_n = PH_TYPE;
								end else fault_n = ST_TYPE;
							end else begin rem_n = vlen_full; ph_n = PH_VALUE; end
						end
						PH_VALUE: begin
							rem_n = rem_dec;
							if (rem_dec == 32'd0) begin
								if (close_ok) begin recs_n = recs_q + 32'd1; ph_n = PH_TYPE; end
								else fault_n = ST_TYPE;
							end
						end
						default: ph_n = PH_TYPE;
					endcase
				end
			end
		end
		priority if (q_item.is_hdr && q_item.hdr_idx != 5'(HdrLen - 1)) st = ST_SHORT;
		else if ({7'd0, pay_n} > {8'd0, max_payload_len_q}) st = ST_BIG;
		else if (w0_n[31:0] != TagWord || w0_n[63:32] != expected_version_q) st = ST_MAGIC;
		else if (w1_n[31:0] > max_records_q) st = ST_COUNT;
		else if (hash_n != w1_n[63:32]) st = ST_HASH;
		else if (fault_n != ST_OK) st = fault_n;
		else if (recs_n != w1_n[31:0]) st = ST_TRUNC;
		else st = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0; w1_q <= '0; w2_q <= '0;
			hash_q <= HashStart; pay_q <= '0; recs_q <= '0; rem_q <= '0;
			vlen_q <= '0; rtype_q <= '0; ph_q <= PH_TYPE; fault_q <= ST_OK;
			out_valid <= 1'b0;
		end else begin
			if (acc && q_item.last) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (acc) begin
				if (q_item.last) begin
					w0_q <= '0; w1_q <= '0; w2_q <= '0;
					hash_q <= HashStart; pay_q <= '0; recs_q <= '0; rem_q <= '0;
					vlen_q <= '0; rtype_q <= '0; ph_q <= PH_TYPE; fault_q <= ST_OK;
				end else begin
					w0_q <= w0_n; w1_q <= w1_n; w2_q <= w2_n;
					hash_q <= hash_n; pay_q <= pay_n; recs_q <= recs_n; rem_q <= rem_n;
					vlen_q <= vlen_n; rtype_q <= rtype_n; ph_q <= ph_n; fault_q <= fault_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && q_item.last) begin
			out_res.status <= st;
			out_res.record_count <= w1_n[31:0];
			out_res.payload_hash <= w1_n[63:32];
			out_res.sequence_number <= w2_n;
		end
	end
endmodule
`default_nettype wire

>>> rtl/kv_record_file_validator_top.sv
// Top level of the key/value record file validator.
//  channel | dir | payload
//  in      | in  | data_byte[7:0], end_of_file
//  out     | out | status, record_count, payload_hash, sequence_number
//  cfg     | in  | cfg_we, cfg_index, cfg_data
// One byte per cycle sustained while the output is not stalled; each byte is
// registered in the queue, and the result is registered when the walk takes the last byte.
// A two-entry queue separates the byte front from the walk.
// Reset clears the walk state and queue pointers and restores register defaults.
// A stalled output holds the walk; the queue fills, then in.ready drops.
`default_nettype none
module kv_record_file_validator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	kvrfv_if.sink            in,
	kvrfv_if.source          out
);
	import kvrfv_pkg::*;
	logic  q_valid, q_ready;
	item_t q_item;
	result_t res;

	kvrfv_front u_front (
		.clk, .arst_n,
		.in_valid(in.valid), .in_ready(in.ready),
		.in_byte(in.payload[8:1]), .in_last(in.payload[0]),
		.q_valid, .q_ready, .q_item
	);

	kvrfv_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.q_valid, .q_ready, .q_item,
		.out_valid(out.valid), .out_ready(out.ready), .out_res(res)
	);
	assign out.payload = res;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.payload))
		else $error("result lost under stall");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> out.payload[131:128] <= ST_TRAIL)
		else $error("status out of range");
endmodule
`default_nettype wire

>>> test/tb_kv_record_file_validator_top.sv
// Self-checking testbench for the key/value record file validator top level.
`default_nettype none
module tb_kv_record_file_validator_top;
	import kvrfv_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	kvrfv_if #(.W(9))   in_ch ();
	kvrfv_if #(.W(132)) out_ch ();

	kv_record_file_validator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in(in_ch), .out(out_ch)
	);

	localparam int unsigned CycleLimit = 1500000;

	// register copies
	logic [31:0] lim_records, lim_string, want_version;
	logic [15:0] lim_key;
	logic [23:0] lim_payload;

	// predictor state
	int unsigned hdr_seen;
	logic [63:0] hdr_w [4];
	logic [31:0] run_hash;
	logic [24:0] pay_seen;
	logic [31:0] rec_done;
	phase_t      walk_phase;
	logic [31:0] remaining;
	logic [7:0]  rec_kind;
	logic [31:0] val_len;
	logic [3:0]  fault;

	result_t     pending_status_q[$];
	int unsigned errors;
	int unsigned cycles;
	int unsigned bytes_sent;
	int unsigned results_seen;
	int unsigned src_idle, snk_idle;

	logic [7:0] file_q[$];
	logic [7:0] pay_q[$];

	always #2 clk = ~clk;

	function automatic void clear_walk();
		hdr_seen = 0;
		foreach (hdr_w[i]) hdr_w[i] = '0;
		run_hash = HashStart;
		pay_seen = '0;
		rec_done = '0;
		walk_phase = PH_TYPE;
		remaining = '0;
		rec_kind = '0;
		val_len = '0;
		fault = ST_OK;
	endfunction

	function automatic void end_value();
		if (rec_kind == 8'd2 || (rec_kind == 8'd1 && val_len == 32'd4)) begin
			rec_done++;
			walk_phase = PH_TYPE;
		end else begin
			fault = ST_TYPE;
		end
	endfunction

	function automatic void walk_record(input logic [7:0] b);
		logic [31:0] klen;
		if (fault != ST_OK) return;
		if (rec_done == hdr_w[1][31:0]) begin
			fault = ST_TRAIL;
			return;
		end
		case (walk_phase)
			PH_TYPE: begin
				rec_kind = b;
				walk_phase = PH_KLEN0;
			end
			PH_KLEN0: begin
				remaining = {24'd0, b};
				walk_phase = PH_KLEN1;
			end
			PH_KLEN1: begin
				klen = {16'd0, b, remaining[7:0]};
				if (klen == 0 || klen > {16'd0, lim_key}) begin
					fault = ST_KEY;
				end else begin
					remaining = klen;
					walk_phase = PH_KEY;
				end
			end
			PH_KEY: begin
				remaining--;
				if (remaining == 0) begin
					val_len = '0;
					walk_phase = PH_VLEN0;
				end
			end
			PH_VLEN0: begin
				val_len[7:0] = b;
				walk_phase = PH_VLEN1;
			end
			PH_VLEN1: begin
				val_len[15:8] = b;
				walk_phase = PH_VLEN2;
			end
			PH_VLEN2: begin
				val_len[23:16] = b;
				walk_phase = PH_VLEN3;
			end
			PH_VLEN3: begin
				val_len[31:24] = b;
				if (rec_kind == 8'd2 && val_len > lim_string) fault = ST_STRING;
				else if (val_len == 0) end_value();
				else begin
					remaining = val_len;
					walk_phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				remaining--;
				if (remaining == 0) end_value();
			end
			default: walk_phase = PH_TYPE;
		endcase
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic last);
		result_t r;
		if (hdr_seen < HdrLen) begin
			hdr_w[hdr_seen / 8][8 * (hdr_seen % 8) +: 8] = b;
			hdr_seen++;
		end else begin
			run_hash = (run_hash ^ {24'd0, b}) * HashMul;
			if (pay_seen != CountCap) pay_seen++;
			walk_record(b);
		end
		if (!last) return;
		r.record_count = hdr_w[1][31:0];
		r.payload_hash = hdr_w[1][63:32];
		r.sequence_number = hdr_w[2];
		if (hdr_seen < HdrLen) r.status = ST_SHORT;
		else if (pay_seen > {1'b0, lim_payload}) r.status = ST_BIG;
		else if (hdr_w[0][31:0] != TagWord || hdr_w[0][63:32] != want_version)
			r.status = ST_MAGIC;
		else if (hdr_w[1][31:0] > lim_records) r.status = ST_COUNT;
		else if (run_hash != hdr_w[1][63:32]) r.status = ST_HASH;
		else if (fault != ST_OK) r.status = fault;
		else if (rec_done != hdr_w[1][31:0]) r.status = ST_TRUNC;
		else r.status = ST_OK;
		pending_status_q = {pending_status_q, r};
		clear_walk();
	endfunction

	// transaction monitor and result checker
	always @(posedge clk) begin
		result_t got, want;
		if (in_ch.valid && in_ch.ready)
			predict_byte(in_ch.payload[8:1], in_ch.payload[0]);
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			results_seen++;
			if (pending_status_q.size() == 0) begin
				errors++;
				$display("%0t result: expected none actual %h", $time, got);
			end else begin
				want = pending_status_q.pop_front();
				if (got.status != want.status) begin
					errors++;
					$display("%0t status: expected %0d actual %0d", $time, want.status,
						got.status);
				end
				if (got.record_count != want.record_count) begin
					errors++;
					$display("%0t record_count: expected %h actual %h", $time,
						want.record_count, got.record_count);
				end
				if (got.payload_hash != want.payload_hash) begin
					errors++;
					$display("%0t payload_hash: expected %h actual %h", $time,
						want.payload_hash, got.payload_hash);
				end
				if (got.sequence_number != want.sequence_number) begin
					errors++;
					$display("%0t sequence_number: expected %h actual %h", $time,
						want.sequence_number, got.sequence_number);
				end
			end
		end
	end

	always @(posedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= {b, last};
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_file();
		foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_status_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_MAX_RECORDS: lim_records = val;
			CFG_MAX_KEY_LEN: lim_key = val[15:0];
			CFG_MAX_STRING_LEN: lim_string = val;
			CFG_MAX_PAYLOAD_LEN: lim_payload = val[23:0];
			CFG_EXPECTED_VERSION: want_version = val;
			default: ;
		endcase
	endtask

	task automatic set_limits(input logic [31:0] recs, input logic [31:0] klen,
			input logic [31:0] slen, input logic [31:0] plen, input logic [31:0] ver);
		wait_drained();
		write_reg(CFG_MAX_RECORDS, recs);
		write_reg(CFG_MAX_KEY_LEN, klen);
		write_reg(CFG_MAX_STRING_LEN, slen);
		write_reg(CFG_MAX_PAYLOAD_LEN, plen);
		write_reg(CFG_EXPECTED_VERSION, ver);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void push_le(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++) file_q = {file_q, v[8 * i +: 8]};
	endfunction

	// vpush caps how many value bytes are actually appended
	function automatic void add_record(input logic [7:0] kind, input int klen,
			input logic [31:0] vlen, input int vpush);
		pay_q = {pay_q, kind};
		pay_q = {pay_q, klen[7:0]};
		pay_q = {pay_q, klen[15:8]};
		for (int i = 0; i < klen; i++) pay_q = {pay_q, 8'($urandom)};
		for (int i = 0; i < 4; i++) pay_q = {pay_q, vlen[8 * i +: 8]};
		for (int i = 0; i < vpush && i < vlen; i++) pay_q = {pay_q, 8'($urandom)};
	endfunction

	function automatic void close_file(input logic [31:0] ver, input logic [31:0] cnt,
			input bit good_hash, input bit good_magic);
		logic [31:0] h, magic;
		h = HashStart;
		foreach (pay_q[i]) h = (h ^ {24'd0, pay_q[i]}) * HashMul;
		if (!good_hash) h ^= 32'd1 << $urandom_range(31);
		magic = good_magic ? TagWord : TagWord ^ (32'd1 << $urandom_range(31));
		file_q = {};
		push_le(magic, 4);
		push_le(ver, 4);
		push_le(cnt, 4);
		push_le(h, 4);
		push_le({$urandom, $urandom}, 8);
		file_q = {file_q, pay_q};
		pay_q = {};
	endfunction

	task automatic short_file(input int n);
		file_q = {};
		for (int i = 0; i < n; i++) file_q = {file_q, 8'($urandom)};
		send_file();
	endtask

	task automatic test_header_checks();
		short_file(1);
		short_file(23);
		close_file(want_version, 0, 1, 1); send_file();
		close_file(want_version, 0, 1, 0); send_file();
		close_file(want_version + 1, 0, 1, 1); send_file();
		add_record(8'd2, 1, 0, 0);
		close_file(want_version, lim_records + 1, 1, 1); send_file();
		add_record(8'd1, 2, 4, 4);
		close_file(want_version, 1, 0, 1); send_file();
	endtask

	task automatic test_record_walk();
		set_limits(32'd50000, 32'd8, 32'd16384, 32'd1048576, 32'd2);
		add_record(8'd1, 0, 4, 4);
		close_file(want_version, 1, 1, 1); send_file();
		add_record(8'd2, lim_key + 1, 0, 0);
		close_file(want_version, 1, 1, 1); send_file();
		add_record(8'd2, 3, lim_string + 1, 2);
		close_file(want_version, 1, 1, 1); send_file();
		add_record(8'd3, 3, 2, 2);
		close_file(want_version, 1, 1, 1); send_file();
		add_record(8'd1, 3, 3, 3);
		close_file(want_version, 1, 1, 1); send_file();
		add_record(8'd1, 1, 4, 4);
		close_file(want_version, 2, 1, 1); send_file();
		add_record(8'd2, 1, 0, 0);
		pay_q = {pay_q, 8'($urandom)};
		close_file(want_version, 1, 1, 1); send_file();
		// bad kind cut off mid-value reads as truncated
		add_record(8'd9, 2, 6, 3);
		close_file(want_version, 1, 1, 1); send_file();
		add_record(8'd2, 4, 0, 0);
		add_record(8'd1, lim_key, 4, 4);
		add_record(8'd2, 1, 7, 7);
		close_file(want_version, 3, 1, 1); send_file();
		set_limits(32'd50000, 32'd256, 32'd16384, 32'd1048576, 32'd2);
	endtask

	task automatic test_register_extremes();
		set_limits(32'd0, 32'd1, 32'd0, 32'd0, 32'd0);
		close_file(32'd0, 0, 1, 1); send_file();
		pay_q = {pay_q, 8'($urandom)};
		close_file(32'd0, 0, 1, 1); send_file();
		set_limits('1, 32'hFFFF, '1, 32'hFFFFFF, '1);
		add_record(8'd2, 3, 32'hFFFFFFFF, 5);
		close_file('1, 1, 1, 1); send_file();
		add_record(8'd1, 2, 4, 4);
		close_file('1, '1, 1, 1); send_file();
		set_limits(32'd5, 32'd0, 32'd4, 32'd64, 32'd2);
		add_record(8'd1, 1, 4, 4);
		close_file(32'd2, 1, 1, 1); send_file();
		set_limits(32'd50000, 32'd256, 32'd16384, 32'd1048576, 32'd2);
	endtask

	task automatic random_file();
		int nrec, r, klen, kmax;
		logic [7:0] kind;
		logic [31:0] vlen, cnt;
		if ($urandom_range(99) < 8) begin
			short_file($urandom_range(1, 40));
			return;
		end
		nrec = $urandom_range(0, 4);
		kmax = (lim_key > 8) ? 8 : lim_key;
		for (int i = 0; i < nrec; i++) begin
			r = $urandom_range(9);
			kind = (r < 4) ? 8'd1 : (r < 8) ? 8'd2 : (r == 8) ? 8'd0 : 8'($urandom);
			klen = $urandom_range(1, kmax);
			if ($urandom_range(99) < 5) klen = ($urandom_range(1)) ? 0 : kmax + 1;
			if (kind == 8'd1 && $urandom_range(9) != 0) vlen = 4;
			else vlen = $urandom_range(0, 9);
			add_record(kind, klen, vlen, vlen);
		end
		cnt = nrec;
		r = $urandom_range(99);
		if (r < 8) cnt = nrec + 1;
		else if (r < 14 && nrec > 0) cnt = nrec - 1;
		if ($urandom_range(99) < 8 && pay_q.size() > 0)
			repeat ($urandom_range(1, pay_q.size())) void'(pay_q.pop_back());
		if ($urandom_range(99) < 6)
			repeat ($urandom_range(1, 5)) pay_q = {pay_q, 8'($urandom)};
		close_file(($urandom_range(99) < 95) ? want_version : $urandom, cnt,
			$urandom_range(99) < 92, $urandom_range(99) < 95);
		send_file();
	endtask

	task automatic test_random_files(input int unsigned byte_goal);
		int unsigned start_bytes, files;
		start_bytes = bytes_sent;
		files = 0;
		while (bytes_sent - start_bytes < byte_goal) begin
			if (files % 8 == 7)
				set_limits($urandom_range(0, 6), $urandom_range(1, 8), $urandom_range(0, 8),
					$urandom_range(20, 300), $urandom_range(0, 3));
			random_file();
			files++;
		end
		set_limits(32'd50000, 32'd256, 32'd16384, 32'd1048576, 32'd2);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_RECORDS;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		lim_records = 32'd50000;
		lim_key = 16'd256;
		lim_string = 32'd16384;
		lim_payload = 24'd1048576;
		want_version = 32'd2;
		clear_walk();
		src_idle = 24;
		snk_idle = 51;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_checks();
		test_record_walk();
		test_register_extremes();
		test_random_files(50);
		wait_drained();
		src_idle = 51;
		snk_idle = 24;
		test_random_files(50);
		wait_drained();
		src_idle = 0;
		snk_idle = 0;
		test_random_files(50);

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
